### sv/alpha_weighted_half_downscale_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the downscaler checker.
// ---------------------------------------------------------------------------
`ifndef ALPHA_WEIGHTED_HALF_DOWNSCALE_ASSERT_SVH
`define ALPHA_WEIGHTED_HALF_DOWNSCALE_ASSERT_SVH

// same-cycle implication
`define AWHD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define AWHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

### sv/awhd_pkg.sv
// ---------------------------------------------------------------------------
// awhd_pkg
// Shared widths, codes and control types of the alpha-weighted downscaler.
// ---------------------------------------------------------------------------
`default_nettype none

package awhd_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 4096;
    localparam int unsigned MAX_HEIGHT    = 4096;
    localparam int unsigned CFG_W         = 13;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned PIX_W         = 8;
    localparam int unsigned PROD_W        = 16;
    localparam int unsigned PAIR_W        = 17;
    localparam int unsigned PAIRA_W       = 9;
    localparam int unsigned SUM_W         = 18;
    localparam int unsigned SUMA_W        = 10;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned LINE_W        = 3 * PAIR_W + PAIRA_W;
    localparam int unsigned DIV_CNT_W     = 5;
    localparam int unsigned RESET_WIDTH   = 640;
    localparam int unsigned RESET_HEIGHT  = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUM  = 7'b0000100,
        S_WR   = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load_px;
        logic mul;
        logic store_left;
        logic make_pair;
        logic mem_wr;
        logic acc;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### sv/awhd_in_if.sv
// ---------------------------------------------------------------------------
// awhd_in_if
// Source pixel channel: valid, ready and one RGBA pixel.
// ---------------------------------------------------------------------------
`default_nettype none

interface awhd_in_if
    import awhd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

`default_nettype wire

### sv/awhd_out_if.sv
// ---------------------------------------------------------------------------
// awhd_out_if
// Result pixel channel: valid, ready and one RGBA pixel.
// ---------------------------------------------------------------------------
`default_nettype none

interface awhd_out_if
    import awhd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_alpha;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_alpha, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input out_alpha, output ready);
endinterface

`default_nettype wire

### sv/awhd_ram.sv
// ---------------------------------------------------------------------------
// awhd_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module awhd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

### sv/awhd_ctrl.sv
// ---------------------------------------------------------------------------
// awhd_ctrl
// Sequencer: frame position counters, configuration and per-pixel steps.
// ---------------------------------------------------------------------------
`default_nettype none

module awhd_ctrl
    import awhd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_status              i_status,
    output t_cmd                      o_cmd,
    output logic [(((MAX_WIDTH + 1) / 2) > 1 ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] o_slot
);
    localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;
    localparam int unsigned SlotW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
    localparam int unsigned ColW      = $clog2(MAX_WIDTH);
    localparam int unsigned EffW      = ColW + 1;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_width, r_height;
    logic [ColW-1:0]    r_col;
    logic [ROW_W-1:0]   r_row;
    logic               r_col_odd, r_row_odd;
    logic [SlotW-1:0]   r_slot;
    logic [EffW-1:0]    w_eff, col_next;
    logic [ROW_W:0]     h_eff, row_next;
    logic               accept;

    always_comb begin
        if (r_width == '0) begin
            w_eff = EffW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = EffW'(MAX_WIDTH);
        end else begin
            w_eff = EffW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = (ROW_W + 1)'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = (ROW_W + 1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W + 1)'(r_height);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;
    assign col_next   = {1'b0, r_col} + EffW'(1);
    assign row_next   = {1'b0, r_row} + (ROW_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= CFG_W'(RESET_WIDTH);
            r_height <= CFG_W'(RESET_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SOURCE_WIDTH:  r_width  <= i_cfg_data;
                    REG_SOURCE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_next >= w_eff) begin
                    r_col <= '0;
                    r_row <= (row_next >= h_eff) ? '0 : row_next[ROW_W-1:0];
                end else begin
                    r_col <= col_next[ColW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col_odd <= r_col[0];
            r_row_odd <= r_row[0];
            r_slot    <= SlotW'(r_col >> 1);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_px = accept;
                if (accept) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                if (!r_col_odd) begin
                    o_cmd.store_left = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.make_pair = 1'b1;
                    n_state         = r_row_odd ? S_ACC : S_WR;
                end
            end
            S_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_slot = r_slot;
endmodule

`default_nettype wire

### sv/awhd_dp.sv
// ---------------------------------------------------------------------------
// awhd_dp
// Datapath: alpha weighting, pair and line sums, three-lane divider, output.
// ---------------------------------------------------------------------------
`default_nettype none

module awhd_dp
    import awhd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [(((MAX_WIDTH + 1) / 2) > 1 ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] i_slot,
    output t_status               o_status,
    input  wire logic [PIX_W-1:0] i_red,
    input  wire logic [PIX_W-1:0] i_green,
    input  wire logic [PIX_W-1:0] i_blue,
    input  wire logic [PIX_W-1:0] i_alpha,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_red,
    output logic [PIX_W-1:0]      o_green,
    output logic [PIX_W-1:0]      o_blue,
    output logic [PIX_W-1:0]      o_alpha
);
    localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;

    logic [PIX_W-1:0]   r_px [4];
    logic [PROD_W-1:0]  r_prod [3];
    logic [PIX_W-1:0]   r_prod_a;
    logic [PROD_W-1:0]  r_left [3];
    logic [PIX_W-1:0]   r_left_a;
    logic [PAIR_W-1:0]  r_pair [3];
    logic [PAIRA_W-1:0] r_pair_a;
    logic [LINE_W-1:0]  mem_wdata, mem_rdata;
    logic [PAIR_W-1:0]  up [3];
    logic [PAIRA_W-1:0] up_a;
    logic [SUMA_W-1:0]  sum_a;
    logic [SUM_W-1:0]   r_dvd [3];
    logic [PIX_W-1:0]   r_rem [3];
    logic [PIX_W-1:0]   r_qa;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PIX_W:0]     rem_sh [3];
    logic [PIX_W:0]     rem_sub [3];
    logic [PIX_W-1:0]   res [3];
    logic               r_valid;
    logic [PIX_W-1:0]   r_out [4];

    assign mem_wdata = {r_pair[0], r_pair[1], r_pair[2], r_pair_a};
    assign {up[0], up[1], up[2], up_a} = mem_rdata;
    assign sum_a = {1'b0, up_a} + {1'b0, r_pair_a};

    awhd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LineDepth)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_addr  (i_slot),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rem_sh[k]  = {r_rem[k], r_dvd[k][SUM_W-1]};
            rem_sub[k] = rem_sh[k] - {1'b0, r_qa};
            if (r_qa == '0) begin
                res[k] = '0;
            end else if (r_dvd[k][SUM_W-1:2] > (SUM_W - 2)'(255)) begin
                res[k] = '1;
            end else begin
                res[k] = r_dvd[k][PIX_W+1:2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) begin
            r_px[0] <= i_red;
            r_px[1] <= i_green;
            r_px[2] <= i_blue;
            r_px[3] <= i_alpha;
        end
        if (i_cmd.mul) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= r_px[k] * r_px[3];
            end
            r_prod_a <= r_px[3];
        end
        if (i_cmd.store_left) begin
            r_left   <= r_prod;
            r_left_a <= r_prod_a;
        end
        if (i_cmd.make_pair) begin
            for (int k = 0; k < 3; k++) begin
                r_pair[k] <= {1'b0, r_left[k]} + {1'b0, r_prod[k]};
            end
            r_pair_a <= {1'b0, r_left_a} + {1'b0, r_prod_a};
        end
        if (i_cmd.acc) begin
            for (int k = 0; k < 3; k++) begin
                r_dvd[k] <= {1'b0, up[k]} + {1'b0, r_pair[k]};
                r_rem[k] <= '0;
            end
            r_qa <= sum_a[SUMA_W-1:2];
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                if (!rem_sub[k][PIX_W] || rem_sh[k] >= {1'b0, r_qa}) begin
                    r_rem[k] <= rem_sub[k][PIX_W-1:0];
                    r_dvd[k] <= {r_dvd[k][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem_sh[k][PIX_W-1:0];
                    r_dvd[k] <= {r_dvd[k][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (i_cmd.out_load) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= res[k];
            end
            r_out[3] <= r_qa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_status.div_done = (r_div_cnt == DIV_CNT_W'(SUM_W - 1));
    assign o_status.out_free = !r_valid || i_ready;

    assign o_valid = r_valid;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
    assign o_alpha = r_out[3];
endmodule

`default_nettype wire

### sv/alpha_weighted_half_downscale.sv
// A closing request passes the multiply, sum, accumulate, divide and output states
// before its result is valid. Pixels are taken only in the idle state, so a pixel
// waits for the last; closing requests also wait on the 18-step three-lane divider.
// Reset: synchronous active low; registers return to 640 x 480, counters clear.
// The line store is not cleared; every pair is written before it is read.
// ---------------------------------------------------------------------------
// alpha_weighted_half_downscale
// Alpha-weighted 2x2 box downscaler for a raster RGBA pixel stream.
// ---------------------------------------------------------------------------
`default_nettype none

module alpha_weighted_half_downscale
    import awhd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    awhd_in_if.sink                   i_pix,
    awhd_out_if.source                o_pix,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);
    localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;
    localparam int unsigned SlotW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;

    t_cmd             cmd;
    t_status          status;
    logic [SlotW-1:0] slot;

    awhd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_slot      (slot)
    );

    awhd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_slot   (slot),
        .o_status (status),
        .i_red    (i_pix.in_red),
        .i_green  (i_pix.in_green),
        .i_blue   (i_pix.in_blue),
        .i_alpha  (i_pix.in_alpha),
        .o_valid  (o_pix.valid),
        .i_ready  (o_pix.ready),
        .o_red    (o_pix.out_red),
        .o_green  (o_pix.out_green),
        .o_blue   (o_pix.out_blue),
        .o_alpha  (o_pix.out_alpha)
    );
endmodule

`default_nettype wire

### sv/awhd_checker.sv
// ---------------------------------------------------------------------------
// awhd_checker
// Port-level checks of the downscaler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "alpha_weighted_half_downscale_assert.svh"

module awhd_checker
    import awhd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [PIX_W-1:0] i_out_red,
    input  wire logic [PIX_W-1:0] i_out_green,
    input  wire logic [PIX_W-1:0] i_out_blue,
    input  wire logic [PIX_W-1:0] i_out_alpha
);
    `AWHD_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `AWHD_ASSERT_SAME(a_zero_alpha_black, i_clk, i_rst_n, i_out_valid && (i_out_alpha == '0), (i_out_red == '0) && (i_out_green == '0) && (i_out_blue == '0))
    `AWHD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_alpha))
endmodule

bind alpha_weighted_half_downscale awhd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red),
    .i_out_green (o_pix.out_green),
    .i_out_blue  (o_pix.out_blue),
    .i_out_alpha (o_pix.out_alpha)
);

`default_nettype wire

### verif/alpha_weighted_half_downscale_tb.sv
// ---------------------------------------------------------------------------
// alpha_weighted_half_downscale_tb
// Self-checking bench for the 2x2 alpha-weighted downscaler: a scoreboard
// class predicts each block result from accepted source pixels, random
// frame sizes and pixel content drive the stream, both sides stall.
// ---------------------------------------------------------------------------
`default_nettype none

module alpha_weighted_half_downscale_tb;
    import awhd_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_pixel;

    localparam int unsigned LINE_SLOTS = DEF_MAX_WIDTH / 2;

    class block_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned col;
        int unsigned row;
        int unsigned left_r, left_g, left_b, left_a;
        int unsigned line_r[LINE_SLOTS];
        int unsigned line_g[LINE_SLOTS];
        int unsigned line_b[LINE_SLOTS];
        int unsigned line_a[LINE_SLOTS];
        t_pixel      blocks_due[$];
        int          errors;

        function void restart(input bit all_regs);
            if (all_regs) begin
                width_reg  = RESET_WIDTH;
                height_reg = RESET_HEIGHT;
            end
            col    = 0;
            row    = 0;
            left_r = 0;
            left_g = 0;
            left_b = 0;
            left_a = 0;
        endfunction

        function void write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
            if (idx == REG_SOURCE_WIDTH) width_reg = val;
            else height_reg = val;
            restart(1'b0);
        endfunction

        function int unsigned clip(input int unsigned v, input int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned sat(input int unsigned v);
            return (v > 255) ? 255 : v;
        endfunction

        function void note_pixel(input t_pixel px);
            int unsigned a, r, g, b, pr, pg, pb, pa, slot, sr, sg, sb, qa;
            t_pixel      res;
            a  = px.alpha;
            r  = px.red * a;
            g  = px.green * a;
            b  = px.blue * a;
            if (col[0] == 1'b0) begin
                left_r = r;
                left_g = g;
                left_b = b;
                left_a = a;
            end else begin
                pr   = left_r + r;
                pg   = left_g + g;
                pb   = left_b + b;
                pa   = left_a + a;
                slot = col >> 1;
                if (row[0] == 1'b0) begin
                    line_r[slot] = pr;
                    line_g[slot] = pg;
                    line_b[slot] = pb;
                    line_a[slot] = pa;
                end else begin
                    sr = line_r[slot] + pr;
                    sg = line_g[slot] + pg;
                    sb = line_b[slot] + pb;
                    qa = (line_a[slot] + pa) / 4;
                    if (qa > 0) begin
                        sr = sr / qa / 4;
                        sg = sg / qa / 4;
                        sb = sb / qa / 4;
                    end else begin
                        sr = 0;
                        sg = 0;
                        sb = 0;
                    end
                    res.red   = sat(sr);
                    res.green = sat(sg);
                    res.blue  = sat(sb);
                    res.alpha = sat(qa);
                    blocks_due.push_back(res);
                end
            end
            col++;
            if (col >= clip(width_reg, DEF_MAX_WIDTH)) begin
                col = 0;
                row++;
                if (row >= clip(height_reg, MAX_HEIGHT)) row = 0;
            end
        endfunction

        function void check_block(input t_pixel got);
            t_pixel want;
            if (blocks_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = blocks_due.pop_front();
            if (got.red !== want.red) begin
                $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                errors++;
            end
            if (got.alpha !== want.alpha) begin
                $display("%0t: alpha expected %0d actual %0d", $time, want.alpha, got.alpha);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    awhd_in_if  pix_in ();
    awhd_out_if pix_out ();

    alpha_weighted_half_downscale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in.sink),
        .o_pix       (pix_out.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    block_scoreboard sb;
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     hold_left;
    bit              hold_req;
    int unsigned     sent;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (pix_out.valid && pix_out.ready)
                sb.check_block({pix_out.out_red, pix_out.out_green,
                                pix_out.out_blue, pix_out.out_alpha});
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_pixel(input t_pixel px);
        pix_in.valid    <= 1'b1;
        pix_in.in_red   <= px.red;
        pix_in.in_green <= px.green;
        pix_in.in_blue  <= px.blue;
        pix_in.in_alpha <= px.alpha;
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_pixel(px);
        sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // hold the stream until the block has drained, then write
    task automatic write_reg(input t_reg_idx idx, input int unsigned val);
        pix_in.valid <= 1'b0;
        while (sb.blocks_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        sb.write_reg(idx, CFG_W'(val));
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
    endtask

    function automatic t_pixel rand_pixel();
        t_pixel px;
        px = $urandom;
        case ($urandom_range(9))
            0: px.alpha = 8'h00;
            1: px.alpha = 8'hff;
            2: px.alpha = $urandom_range(1, 7);
            default: ;
        endcase
        return px;
    endfunction

    task automatic send_table(input logic [31:0] vals[]);
        foreach (vals[k]) send_pixel(vals[k]);
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned stop_at, w, h, weff, heff, n;
        stop_at = sent + target;
        hold_req = 1'b1;
        while (sent < stop_at) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
            h = $urandom_range(0, 7);
            set_size(w, h);
            weff = (w == 0) ? 1 : w;
            heff = (h == 0) ? 1 : h;
            n = weff * heff * $urandom_range(1, 3);
            if ($urandom_range(3) == 0) n += $urandom_range(0, weff);
            repeat (n) send_pixel(rand_pixel());
        end
    endtask

    initial begin
        sb = new();
        sb.restart(1'b1);
        sb.errors   = 0;
        sent        = 0;
        hold_req    = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= REG_SOURCE_WIDTH;
        i_cfg_data      <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.in_red   <= '0;
        pix_in.in_green <= '0;
        pix_in.in_blue  <= '0;
        pix_in.in_alpha <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_size(4, 2);
        send_table('{32'hffffffff, 32'hffffffff, 32'hffffff00, 32'hffffff00,
                     32'hffffffff, 32'hffffffff, 32'hffffff00, 32'hffffff00});
        send_table('{32'hffffff07, 32'h00000000, 32'hff8001ff, 32'h00000001,
                     32'h00000000, 32'h00000000, 32'h12345601, 32'habcdef01});
        set_size(3, 3);
        send_table('{32'h10203040, 32'h50607080, 32'h90a0b0c0,
                     32'hd0e0f0ff, 32'h01020304, 32'h05060708,
                     32'h7f7f7f7f, 32'h80808080, 32'hfefefefe});

        tx_idle_pct = 9;
        rx_idle_pct = 50;
        random_phase(320);
        tx_idle_pct = 50;
        rx_idle_pct = 9;
        random_phase(320);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(320);

        // width and height registers beyond the limit, then the smallest frame
        set_size(8191, 2);
        repeat (32) send_pixel(rand_pixel());
        set_size(2, 8191);
        repeat (16) send_pixel(rand_pixel());
        set_size(1, 1);
        repeat (4) send_pixel(rand_pixel());

        pix_in.valid <= 1'b0;
        while (sb.blocks_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/awhd_pkg.sv
sv/awhd_in_if.sv
sv/awhd_out_if.sv
sv/awhd_ram.sv
sv/awhd_ctrl.sv
sv/awhd_dp.sv
sv/alpha_weighted_half_downscale.sv
sv/awhd_checker.sv
verif/alpha_weighted_half_downscale_tb.sv
